@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker module sbc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, muted while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check on the rising clock that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Widths, codes and record types of the swept box collision block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbc_pkg;

   // Fraction bits of the output times
   localparam int FRAC_BITS  = 16;
   // Coordinate and size widths
   localparam int IN_W       = 32;
   localparam int SZ_W       = 31;
   // Gaps and velocities are formed exactly in this many bits
   localparam int GAP_W      = IN_W + 2;
   // Scaled numerator and signed quotient widths
   localparam int NUM_W      = GAP_W + FRAC_BITS;
   localparam int QUO_W      = NUM_W + 1;
   // Divider depth: one quotient bit a stage plus the sign fix
   localparam int DIV_LAT    = NUM_W + 1;
   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic signed [QUO_W-1:0] ONE_T    = QUO_W'(64'd1 << FRAC_BITS);
   localparam logic signed [QUO_W-1:0] TIME_MAX = QUO_W'(64'sd2147483647);
   localparam logic signed [QUO_W-1:0] TIME_MIN = -QUO_W'(64'sd2147483648);

   typedef enum logic [2:0] {
      SIDE_NONE    = 3'd0,
      SIDE_LEFT    = 3'd1,
      SIDE_RIGHT   = 3'd2,
      SIDE_TOP     = 3'd3,
      SIDE_BOTTOM  = 3'd4,
      SIDE_UNKNOWN = 3'd5
   } side_type;

   typedef enum logic [1:0] {
      AX_NEVER,
      AX_ALWAYS,
      AX_SOMETIME
   } axis_kind_type;

   // Outcome known before the times are compared
   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_UNKNOWN,
      PRE_TEST
   } pre_type;

   // One axis after classification
   typedef struct packed {
      axis_kind_type      kind;
      logic               vpos;
      logic [GAP_W-1:0]   n0_mag;
      logic               n0_neg;
      logic [GAP_W-1:0]   n1_mag;
      logic               n1_neg;
      logic [GAP_W-1:0]   den;
   } axis_rec_type;

   // One classified request, front to back
   typedef struct packed {
      axis_rec_type x;
      axis_rec_type y;
   } front_rec_type;

   // Control carried beside the dividers
   typedef struct packed {
      axis_kind_type kx;
      axis_kind_type ky;
      logic          vxpos;
      logic          vypos;
   } side_band_type;

endpackage

@@ rtl/sbc_front.sv @@
// ----------------------------------------------------------------------------
// sbc_front
// Accepts requests, forms relative velocity and gaps, classifies each axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_front
   import sbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SZ_W-1:0]        req_a_width,
   input  logic [SZ_W-1:0]        req_a_height,
   input  logic signed [IN_W-1:0] req_a_start_x,
   input  logic signed [IN_W-1:0] req_a_start_y,
   input  logic signed [IN_W-1:0] req_a_end_x,
   input  logic signed [IN_W-1:0] req_a_end_y,
   input  logic [SZ_W-1:0]        req_b_width,
   input  logic [SZ_W-1:0]        req_b_height,
   input  logic signed [IN_W-1:0] req_b_start_x,
   input  logic signed [IN_W-1:0] req_b_start_y,
   input  logic signed [IN_W-1:0] req_b_end_x,
   input  logic signed [IN_W-1:0] req_b_end_y,
   output front_rec_type          rec,
   output logic                   rec_valid,
   input  logic                   rec_ready
);

   front_rec_type             rec_ff, rec_in;
   logic                      valid_ff, valid_in;
   logic signed [GAP_W-1:0]   vx, vy;
   logic                      accept;

   // Per axis gaps, divisor and overlap kind
   function automatic axis_rec_type classify(
      input logic signed [IN_W-1:0]  a_lo,
      input logic [SZ_W-1:0]         a_sz,
      input logic signed [IN_W-1:0]  b_lo,
      input logic [SZ_W-1:0]         b_sz,
      input logic signed [GAP_W-1:0] v
   );
      logic signed [GAP_W-1:0] alo, blo, ahi, bhi, n0, n1;
      axis_rec_type            r;
      alo = GAP_W'(a_lo);
      blo = GAP_W'(b_lo);
      ahi = alo + $signed(GAP_W'(a_sz));
      bhi = blo + $signed(GAP_W'(b_sz));
      r.vpos = (v > 0);
      if (v == 0) begin
         r.kind = (ahi <= blo || alo >= bhi) ? AX_NEVER : AX_ALWAYS;
         n0     = '0;
         n1     = '0;
         r.den  = GAP_W'(1);
      end else if (v > 0) begin
         r.kind = AX_SOMETIME;
         n0     = alo - bhi;
         n1     = ahi - blo;
         r.den  = $unsigned(v);
      end else begin
         r.kind = AX_SOMETIME;
         n0     = blo - ahi;
         n1     = bhi - alo;
         r.den  = $unsigned(-v);
      end
      r.n0_neg = n0[GAP_W-1];
      r.n1_neg = n1[GAP_W-1];
      r.n0_mag = r.n0_neg ? $unsigned(-n0) : $unsigned(n0);
      r.n1_mag = r.n1_neg ? $unsigned(-n1) : $unsigned(n1);
      return r;
   endfunction

   // B's motion relative to A
   assign vx = (GAP_W'(req_b_end_x) - GAP_W'(req_b_start_x))
             - (GAP_W'(req_a_end_x) - GAP_W'(req_a_start_x));
   assign vy = (GAP_W'(req_b_end_y) - GAP_W'(req_b_start_y))
             - (GAP_W'(req_a_end_y) - GAP_W'(req_a_start_y));

   assign req_ready = !valid_ff || rec_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (accept) begin
         rec_in.x = classify(req_a_start_x, req_a_width, req_b_start_x, req_b_width, vx);
         rec_in.y = classify(req_a_start_y, req_a_height, req_b_start_y, req_b_height, vy);
         valid_in = 1'b1;
      end else if (rec_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rec_ff <= rec_in;
   end

   assign rec       = rec_ff;
   assign rec_valid = valid_ff;

endmodule

@@ rtl/sbc_fifo.sv @@
// ----------------------------------------------------------------------------
// sbc_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_fifo
   import sbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  front_rec_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output front_rec_type pop_data
);

   front_rec_type        slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != FIFO_CW'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/sbc_div.sv @@
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider, one quotient bit a stage, floor rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_div
   import sbc_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic [NUM_W-1:0]        num,
   input  logic                    num_neg,
   input  logic [GAP_W-1:0]        den,
   output logic signed [QUO_W-1:0] quo
);

   // nq holds the numerator bits still to come and the quotient bits so far
   logic [NUM_W-1:0]        nq_ff  [NUM_W];
   logic [GAP_W-1:0]        rem_ff [NUM_W];
   logic [GAP_W-1:0]        den_ff [NUM_W];
   logic                    neg_ff [NUM_W];
   logic [NUM_W-1:0]        nq_p   [NUM_W];
   logic [GAP_W-1:0]        rem_p  [NUM_W];
   logic [GAP_W-1:0]        den_p  [NUM_W];
   logic                    neg_p  [NUM_W];
   logic [GAP_W:0]          sh     [NUM_W];
   logic [GAP_W:0]          diff   [NUM_W];
   logic                    ge     [NUM_W];
   logic [QUO_W-1:0]        mag;
   logic signed [QUO_W-1:0] quo_ff;

   // One trial subtract per stage
   always_comb begin
      for (int i = 0; i < NUM_W; i++) begin
         if (i == 0) begin
            nq_p[i]  = num;
            rem_p[i] = '0;
            den_p[i] = den;
            neg_p[i] = num_neg;
         end else begin
            nq_p[i]  = nq_ff[i-1];
            rem_p[i] = rem_ff[i-1];
            den_p[i] = den_ff[i-1];
            neg_p[i] = neg_ff[i-1];
         end
         sh[i]   = {rem_p[i], nq_p[i][NUM_W-1]};
         diff[i] = sh[i] - {1'b0, den_p[i]};
         ge[i]   = (sh[i] >= {1'b0, den_p[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            nq_ff[i]  <= {nq_p[i][NUM_W-2:0], ge[i]};
            rem_ff[i] <= ge[i] ? diff[i][GAP_W-1:0] : sh[i][GAP_W-1:0];
            den_ff[i] <= den_p[i];
            neg_ff[i] <= neg_p[i];
         end
      end
   end

   // Negative numerator: -q, minus one more when the remainder is nonzero
   assign mag = {1'b0, nq_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[NUM_W-1] ? $signed(~mag + QUO_W'(rem_ff[NUM_W-1] == '0))
                                   : $signed(mag);
      end
   end

   assign quo = quo_ff;

endmodule

@@ rtl/sbc_back.sv @@
// ----------------------------------------------------------------------------
// sbc_back
// Divides the four gaps, combines the axes and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbc_back
   import sbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  front_rec_type          rec,
   input  logic                   rec_valid,
   output logic                   rec_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_entry_side,
   output logic [2:0]             rsp_exit_side,
   output logic signed [IN_W-1:0] rsp_entry_time,
   output logic signed [IN_W-1:0] rsp_exit_time
);

   logic                    adv;
   logic signed [QUO_W-1:0] x0, x1, y0, y1;
   side_band_type           sb_ff  [DIV_LAT];
   logic                    vld_ff [DIV_LAT];
   side_band_type           sb_in;
   side_band_type           sb_last;

   // Combine stage
   pre_type                 c_pre_ff, c_pre_in;
   logic signed [QUO_W-1:0] c_t0_ff, c_t0_in, c_t1_ff, c_t1_in;
   side_type                c_es_ff, c_es_in, c_xs_ff, c_xs_in;
   logic                    c_vld_ff;
   logic                    x_in_first, x_out_first;

   // Response register
   logic                    out_vld_ff;
   side_type                es_ff, es_in, xs_ff, xs_in;
   logic signed [IN_W-1:0]  et_ff, et_in, xt_ff, xt_in;

   function automatic logic signed [IN_W-1:0] sat_time(input logic signed [QUO_W-1:0] t);
      logic signed [IN_W-1:0] r;
      if (t > TIME_MAX) begin
         r = TIME_MAX[IN_W-1:0];
      end else if (t < TIME_MIN) begin
         r = TIME_MIN[IN_W-1:0];
      end else begin
         r = t[IN_W-1:0];
      end
      return r;
   endfunction

   // The whole back pipeline moves when the response slot frees up
   assign adv       = !out_vld_ff || rsp_ready;
   assign rec_ready = adv;

   sbc_div u_div_x0 (
      .clock(clock), .en(adv),
      .num({rec.x.n0_mag, {FRAC_BITS{1'b0}}}), .num_neg(rec.x.n0_neg),
      .den(rec.x.den), .quo(x0)
   );
   sbc_div u_div_x1 (
      .clock(clock), .en(adv),
      .num({rec.x.n1_mag, {FRAC_BITS{1'b0}}}), .num_neg(rec.x.n1_neg),
      .den(rec.x.den), .quo(x1)
   );
   sbc_div u_div_y0 (
      .clock(clock), .en(adv),
      .num({rec.y.n0_mag, {FRAC_BITS{1'b0}}}), .num_neg(rec.y.n0_neg),
      .den(rec.y.den), .quo(y0)
   );
   sbc_div u_div_y1 (
      .clock(clock), .en(adv),
      .num({rec.y.n1_mag, {FRAC_BITS{1'b0}}}), .num_neg(rec.y.n1_neg),
      .den(rec.y.den), .quo(y1)
   );

   // Side band that travels beside the dividers
   assign sb_in = '{kx: rec.x.kind, ky: rec.y.kind, vxpos: rec.x.vpos, vypos: rec.y.vpos};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= rec_valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      if (adv) begin
         sb_ff[0] <= sb_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   assign sb_last     = sb_ff[DIV_LAT-1];
   assign x_in_first  = (x0 >= y0);
   assign x_out_first = (x1 <= y1);

   // Merge the two axes into one contact interval
   always_comb begin
      c_pre_in = PRE_TEST;
      c_t0_in  = x0;
      c_t1_in  = x1;
      c_es_in  = sb_last.vxpos ? SIDE_LEFT : SIDE_RIGHT;
      c_xs_in  = sb_last.vxpos ? SIDE_RIGHT : SIDE_LEFT;
      if (sb_last.kx == AX_NEVER || sb_last.ky == AX_NEVER) begin
         c_pre_in = PRE_NONE;
      end else if (sb_last.kx == AX_ALWAYS && sb_last.ky == AX_ALWAYS) begin
         c_pre_in = PRE_UNKNOWN;
      end else if (sb_last.kx == AX_SOMETIME && sb_last.ky == AX_SOMETIME) begin
         // Ties go to the x axis
         if (!x_in_first) begin
            c_t0_in = y0;
            c_es_in = sb_last.vypos ? SIDE_TOP : SIDE_BOTTOM;
         end
         if (!x_out_first) begin
            c_t1_in = y1;
            c_xs_in = sb_last.vypos ? SIDE_BOTTOM : SIDE_TOP;
         end
      end else if (sb_last.kx == AX_ALWAYS) begin
         c_t0_in = y0;
         c_t1_in = y1;
         c_es_in = sb_last.vypos ? SIDE_TOP : SIDE_BOTTOM;
         c_xs_in = sb_last.vypos ? SIDE_BOTTOM : SIDE_TOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= vld_ff[DIV_LAT-1];
      end
      if (adv) begin
         c_pre_ff <= c_pre_in;
         c_t0_ff  <= c_t0_in;
         c_t1_ff  <= c_t1_in;
         c_es_ff  <= c_es_in;
         c_xs_ff  <= c_xs_in;
      end
   end

   // Hit window test and saturation
   always_comb begin
      es_in = SIDE_NONE;
      xs_in = SIDE_NONE;
      et_in = '0;
      xt_in = '0;
      priority if (c_pre_ff == PRE_NONE) begin
         es_in = SIDE_NONE;
      end else if (c_pre_ff == PRE_UNKNOWN) begin
         es_in = SIDE_UNKNOWN;
      end else if (c_t0_ff >= c_t1_ff) begin
         es_in = SIDE_NONE;
      end else if (c_t0_ff < 0 && c_t1_ff >= ONE_T) begin
         es_in = SIDE_UNKNOWN;
      end else if (c_t0_ff >= 0 && c_t0_ff < ONE_T) begin
         es_in = c_es_ff;
         xs_in = c_xs_ff;
         et_in = sat_time(c_t0_ff);
         xt_in = sat_time(c_t1_ff);
      end else begin
         es_in = SIDE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         es_ff <= es_in;
         xs_ff <= xs_in;
         et_ff <= et_in;
         xt_ff <= xt_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_entry_side = es_ff;
   assign rsp_exit_side  = xs_ff;
   assign rsp_entry_time = et_ff;
   assign rsp_exit_time  = xt_ff;

endmodule

@@ rtl/swept_box_collision.sv @@
// ----------------------------------------------------------------------------
// swept_box_collision
// Path from request to response: front register, queue, 50 divider bit stages
//   plus sign fix, combine stage, response register.
// Throughput: one request per cycle while rsp_ready keeps the response moving; set by the four pipelined dividers.
// Reset: synchronous, clears all valid flags and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swept_box_collision
   import sbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SZ_W-1:0]        req_a_width,
   input  logic [SZ_W-1:0]        req_a_height,
   input  logic signed [IN_W-1:0] req_a_start_x,
   input  logic signed [IN_W-1:0] req_a_start_y,
   input  logic signed [IN_W-1:0] req_a_end_x,
   input  logic signed [IN_W-1:0] req_a_end_y,
   input  logic [SZ_W-1:0]        req_b_width,
   input  logic [SZ_W-1:0]        req_b_height,
   input  logic signed [IN_W-1:0] req_b_start_x,
   input  logic signed [IN_W-1:0] req_b_start_y,
   input  logic signed [IN_W-1:0] req_b_end_x,
   input  logic signed [IN_W-1:0] req_b_end_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_entry_side,
   output logic [2:0]             rsp_exit_side,
   output logic signed [IN_W-1:0] rsp_entry_time,
   output logic signed [IN_W-1:0] rsp_exit_time
);

   front_rec_type front_rec, queue_rec;
   logic          front_valid, front_ready, queue_valid, queue_ready;

   // Classify requests
   sbc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_width(req_a_width), .req_a_height(req_a_height),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_width(req_b_width), .req_b_height(req_b_height),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rec(front_rec), .rec_valid(front_valid), .rec_ready(front_ready)
   );

   // Decouple front and back
   sbc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(front_valid), .push_ready(front_ready), .push_data(front_rec),
      .pop_valid(queue_valid), .pop_ready(queue_ready), .pop_data(queue_rec)
   );

   // Divide, combine and respond
   sbc_back u_back (
      .clock(clock), .reset(reset),
      .rec(queue_rec), .rec_valid(queue_valid), .rec_ready(queue_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_entry_side(rsp_entry_side), .rsp_exit_side(rsp_exit_side),
      .rsp_entry_time(rsp_entry_time), .rsp_exit_time(rsp_exit_time)
   );

endmodule

@@ rtl/sbc_checker.sv @@
// ----------------------------------------------------------------------------
// sbc_checker
// Port level checks on the response channel of swept_box_collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbc_checker
   import sbc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [2:0]             rsp_entry_side,
   input logic [2:0]             rsp_exit_side,
   input logic signed [IN_W-1:0] rsp_entry_time,
   input logic signed [IN_W-1:0] rsp_exit_time
);

   // A stalled response stays
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_time) && $stable(rsp_exit_time), "stalled response dropped or changed")

   // Nothing comes out right after reset
   `ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "response valid after reset")

   // Miss and unknown responses carry no times and no exit side
   `ASSERT_CLK(a_miss_zero, rsp_valid && (rsp_entry_side == SIDE_NONE || rsp_entry_side == SIDE_UNKNOWN) |-> rsp_entry_time == 0 && rsp_exit_time == 0 && rsp_exit_side == SIDE_NONE, "miss carries data")

   // A hit enters at a nonnegative time and leaves later
   `ASSERT_CLK(a_hit_time, rsp_valid && rsp_entry_side != SIDE_NONE && rsp_entry_side != SIDE_UNKNOWN |-> !rsp_entry_time[IN_W-1] && rsp_exit_time > rsp_entry_time, "bad hit interval")

endmodule

bind swept_box_collision sbc_checker u_sbc_checker (.*);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks swept_box_collision against an in-bench predictor of the swept box
// test: a directed table of corner cases, then random queries mostly built as
// approaching boxes, with random idling on both sides and one long response
// hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sbc_pkg::*;

   localparam int N_RANDOM = 900;
   localparam int N_FIELDS = 12;

   typedef struct packed {
      logic [2:0]  entry_side;
      logic [2:0]  exit_side;
      logic [31:0] entry_time;
      logic [31:0] exit_time;
   } hit_type;

   typedef struct {
      logic [31:0] f [N_FIELDS];
      bit          typed;
      hit_type     hit;
   } query_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SZ_W-1:0] req_a_width = '0, req_a_height = '0, req_b_width = '0, req_b_height = '0;
   logic signed [IN_W-1:0] req_a_start_x = '0, req_a_start_y = '0;
   logic signed [IN_W-1:0] req_a_end_x = '0, req_a_end_y = '0;
   logic signed [IN_W-1:0] req_b_start_x = '0, req_b_start_y = '0;
   logic signed [IN_W-1:0] req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_entry_side, rsp_exit_side;
   logic signed [IN_W-1:0] rsp_entry_time, rsp_exit_time;

   hit_type   hit_queue [$];
   query_type stim [$];
   int  errors = 0;
   bit  sending_done = 0;
   bit  hold_off = 0;
   int  accepted = 0;

   always #2 clock = ~clock;

   swept_box_collision u_dut (.*);

   // ---- predictor -------------------------------------------------------
   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic void sweep(input longint alo, asz, blo, bsz, v,
                                 output axis_kind_type kind, output longint t0, t1);
      longint ahi, bhi, n0, n1, d;
      ahi = alo + asz;
      bhi = blo + bsz;
      t0 = 0;
      t1 = 0;
      if (v == 0) begin
         kind = (ahi <= blo || alo >= bhi) ? AX_NEVER : AX_ALWAYS;
         return;
      end
      if (v > 0) begin
         n0 = alo - bhi; n1 = ahi - blo; d = v;
      end else begin
         n0 = blo - ahi; n1 = bhi - alo; d = -v;
      end
      kind = AX_SOMETIME;
      t0 = floor_quot(n0 <<< FRAC_BITS, d);
      t1 = floor_quot(n1 <<< FRAC_BITS, d);
   endfunction

   function automatic logic [31:0] clamp_time(longint t);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
   endfunction

   function automatic hit_type predict_contact(logic [31:0] f [N_FIELDS]);
      hit_type h;
      longint aw, ah, bw, bh, asx, asy, aex, aey, bsx, bsy, bex, bey, vx, vy;
      longint xt0, xt1, yt0, yt1, t0, t1, one;
      axis_kind_type kx, ky;
      side_type es, xs;
      one = longint'(1) <<< FRAC_BITS;
      aw = f[0][30:0]; ah = f[1][30:0]; bw = f[6][30:0]; bh = f[7][30:0];
      asx = $signed(f[2]); asy = $signed(f[3]); aex = $signed(f[4]); aey = $signed(f[5]);
      bsx = $signed(f[8]); bsy = $signed(f[9]); bex = $signed(f[10]); bey = $signed(f[11]);
      vx = (bex - bsx) - (aex - asx);
      vy = (bey - bsy) - (aey - asy);
      sweep(asx, aw, bsx, bw, vx, kx, xt0, xt1);
      sweep(asy, ah, bsy, bh, vy, ky, yt0, yt1);
      h = '{SIDE_NONE, SIDE_NONE, 0, 0};
      if (kx == AX_NEVER || ky == AX_NEVER) return h;
      if (kx == AX_ALWAYS && ky == AX_ALWAYS) begin
         h.entry_side = SIDE_UNKNOWN;
         return h;
      end
      if (kx == AX_SOMETIME && ky == AX_SOMETIME) begin
         t0 = xt0 > yt0 ? xt0 : yt0;
         t1 = xt1 < yt1 ? xt1 : yt1;
         if (t0 == xt0) es = vx > 0 ? SIDE_LEFT : SIDE_RIGHT;
         else es = vy > 0 ? SIDE_TOP : SIDE_BOTTOM;
         if (t1 == xt1) xs = vx < 0 ? SIDE_LEFT : SIDE_RIGHT;
         else xs = vy < 0 ? SIDE_TOP : SIDE_BOTTOM;
      end else if (kx == AX_ALWAYS) begin
         t0 = yt0; t1 = yt1;
         es = vy > 0 ? SIDE_TOP : SIDE_BOTTOM;
         xs = vy < 0 ? SIDE_TOP : SIDE_BOTTOM;
      end else begin
         t0 = xt0; t1 = xt1;
         es = vx > 0 ? SIDE_LEFT : SIDE_RIGHT;
         xs = vx < 0 ? SIDE_LEFT : SIDE_RIGHT;
      end
      if (t0 >= t1) return h;
      if (t0 < 0 && t1 >= one) begin
         h.entry_side = SIDE_UNKNOWN;
         return h;
      end
      if (t0 >= 0 && t0 < one)
         h = '{es, xs, clamp_time(t0), clamp_time(t1)};
      return h;
   endfunction

   // ---- stimulus construction -------------------------------------------
   function automatic query_type make_query(longint aw, ah, asx, asy, aex, aey,
                                            longint bw, bh, bsx, bsy, bex, bey);
      query_type q;
      q.f = '{aw[31:0], ah[31:0], asx[31:0], asy[31:0], aex[31:0], aey[31:0],
              bw[31:0], bh[31:0], bsx[31:0], bsy[31:0], bex[31:0], bey[31:0]};
      q.typed = 0;
      return q;
   endfunction

   function automatic query_type with_result(query_type q, side_type es, side_type xs,
                                             logic [31:0] t0, logic [31:0] t1);
      q.typed = 1;
      q.hit = '{es, xs, t0, t1};
      return q;
   endfunction

   // random size: mostly small, sometimes full range
   function automatic longint rand_size();
      case ($urandom_range(0, 9))
         0: return $urandom_range(1, 32'h7fffffff);
         1: return 32'h7fffffff;
         2: return 1;
         default: return $urandom_range(1, 32'h0040_0000);
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      longint aw, ah, bw, bh, ax, ay, bx, by, dx, dy;
      int k;
      k = $urandom_range(0, 99);
      if (k < 20) begin
         // raw noise over the whole field range
         for (int i = 0; i < N_FIELDS; i++) q.f[i] = $urandom();
         if (q.f[0][30:0] == 0) q.f[0] = 1;
         if (q.f[1][30:0] == 0) q.f[1] = 1;
         if (q.f[6][30:0] == 0) q.f[6] = 1;
         if (q.f[7][30:0] == 0) q.f[7] = 1;
         q.f[0][31] = 0; q.f[1][31] = 0; q.f[6][31] = 0; q.f[7][31] = 0;
         q.typed = 0;
         return q;
      end
      // B approaches A; A moves a little
      aw = rand_size(); ah = rand_size(); bw = rand_size(); bh = rand_size();
      ax = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      ay = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      bx = ax + ($signed($urandom()) >>> $urandom_range(6, 14));
      by = ay + ($signed($urandom()) >>> $urandom_range(6, 14));
      dx = (ax - bx) * int'($urandom_range(0, 4)) / 2;
      dy = (ay - by) * int'($urandom_range(0, 4)) / 2;
      if ($urandom_range(0, 4) == 0) dx = 0;
      if ($urandom_range(0, 4) == 0) dy = 0;
      q = make_query(aw, ah, ax, ay, ax + $signed($urandom_range(0, 255)) - 128,
                     ay + $signed($urandom_range(0, 255)) - 128, bw, bh, bx, by,
                     bx + dx, by + dy);
      for (int i = 0; i < N_FIELDS; i++) if (i != 0 && i != 1 && i != 6 && i != 7)
         q.f[i] = q.f[i];
      return q;
   endfunction

   // append one row to the stimulus list
   function automatic void add_row(query_type q);
      stim.insert(stim.size(), q);
   endfunction

   // directed table
   initial begin
      longint one, mx, mn;
      one = 64'd1 << 16;
      mx = 32'sh7fffffff;
      mn = -64'sd2147483648;
      // both still and overlapping: already overlapping
      add_row(with_result(make_query(one, one, 0, 0, 0, 0, one, one, 0, 0, 0, 0),
                          SIDE_UNKNOWN, SIDE_NONE, 0, 0));
      // still and apart on x: never
      add_row(with_result(make_query(one, one, 0, 0, 0, 0, one, one, 2*one, 0,
                                     2*one, 0), SIDE_NONE, SIDE_NONE, 0, 0));
      // touching edges on x, still: never
      add_row(with_result(make_query(one, one, 0, 0, 0, 0, one, one, one, 0,
                                     one, 0), SIDE_NONE, SIDE_NONE, 0, 0));
      // B sliding in along x or y from either side, the other axis always
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 2*one, 0, 0, 0));
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, -2*one, 0, 0, 0));
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 0, 2*one, 0, 0));
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 0, -2*one, 0, 0));
      // diagonal approach, the first with a tie between axes
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 2*one, 2*one, 0, 0));
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, -2*one, 3*one, 0, 0));
      // A moves instead of B
      add_row(make_query(one, one, 0, 0, 3*one, one/2, one, one, 2*one, 0,
                         2*one, 0));
      // inside the whole move along x
      add_row(make_query(4*one, 4*one, 0, 0, 0, 0, one, one, one, one, 2*one,
                         one));
      // empty interval, entry after the move
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 9*one, 0, 8*one, 0));
      // moving away
      add_row(make_query(one, one, 0, 0, 0, 0, one, one, 2*one, 0, 4*one, 0));
      // extremes of coordinates and sizes
      add_row(make_query(mx, mx, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn));
      add_row(make_query(1, 1, mx, mx, mn, mn, 1, 1, mn, mn, mx, mx));
      add_row(make_query(mx, 1, mn, mx, mn, mx, 1, mx, mx, mn, mx, mn));
      add_row(make_query(1, 1, 0, 0, 0, 0, 1, 1, 2, 0, 1, 0));
      add_row(make_query(mx, mx, -1, -1, -1, -1, mx, mx, mn, mn, mn, mn));
      add_row(make_query(1, mx, 0, 0, 1, 0, mx, 1, 0, 0, -1, 0));
      // huge relative speed gives tiny times
      add_row(make_query(one, one, mn, 0, mx, 0, one, one, 0, 0, 0, 0));
      for (int i = 0; i < N_RANDOM; i++) add_row(rand_query());
   end

   // ---- request driver ---------------------------------------------------
   initial begin
      query_type q;
      hit_type   h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stim.size(); i++) begin
         q = stim[i];
         while (!(i >= 300 && i < 400) && $urandom_range(0, 99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         {req_a_width, req_a_height} <= {q.f[0][30:0], q.f[1][30:0]};
         {req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y} <=
            {q.f[2], q.f[3], q.f[4], q.f[5]};
         {req_b_width, req_b_height} <= {q.f[6][30:0], q.f[7][30:0]};
         {req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y} <=
            {q.f[8], q.f[9], q.f[10], q.f[11]};
         do @(posedge clock); while (!req_ready);
         h = predict_contact(q.f);
         if (q.typed && h != q.hit) begin
            $display("%0t table row %0d: expected %0d %0d %h %h, predictor %0d %0d %h %h",
                     $time, i, q.hit.entry_side, q.hit.exit_side, q.hit.entry_time,
                     q.hit.exit_time, h.entry_side, h.exit_side, h.entry_time,
                     h.exit_time);
            errors++;
         end
         hit_queue.insert(hit_queue.size(), q.typed ? q.hit : h);
         accepted++;
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   // ---- long hold-off on the response side ------------------------------
   initial begin
      wait (accepted >= 150);
      @(posedge clock);
      hold_off = 1;
      repeat (200) @(posedge clock);
      hold_off = 0;
   end

   // ---- response ready --------------------------------------------------
   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else if (accepted >= 500 && accepted < 650) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) >= 20);
   end

   // ---- response checker ------------------------------------------------
   always @(posedge clock) begin
      hit_type h;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            $display("%0t response with nothing expected: %0d %0d %h %h", $time,
                     rsp_entry_side, rsp_exit_side, rsp_entry_time, rsp_exit_time);
            errors++;
         end else begin
            h = hit_queue.pop_front();
            if (rsp_entry_side !== h.entry_side) begin
               $display("%0t entry_side expected %0d actual %0d", $time, h.entry_side,
                        rsp_entry_side);
               errors++;
            end
            if (rsp_exit_side !== h.exit_side) begin
               $display("%0t exit_side expected %0d actual %0d", $time, h.exit_side,
                        rsp_exit_side);
               errors++;
            end
            if (rsp_entry_time !== h.entry_time) begin
               $display("%0t entry_time expected %h actual %h", $time, h.entry_time,
                        rsp_entry_time);
               errors++;
            end
            if (rsp_exit_time !== h.exit_time) begin
               $display("%0t exit_time expected %h actual %h", $time, h.exit_time,
                        rsp_exit_time);
               errors++;
            end
         end
      end
   end

   // ---- end of run ------------------------------------------------------
   initial begin
      wait (sending_done);
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0 && hit_queue.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
